// ===== design/cfra_pkg.sv =====
package cfra_pkg;

    // Field widths
    localparam int X_W      = 32;
    localparam int TOL_W    = 32;
    localparam int NUM_W    = 32;
    localparam int DEN_W    = 33;
    localparam int ITER_W   = 7;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_TOLERANCE = 1'b0;

    // Parameter defaults
    localparam int FRAC_BITS_DEF = 32;
    localparam int MAX_ITER_DEF  = 100;

    // Result of one expansion
    typedef struct packed {
        logic [NUM_W-1:0]  numerator;
        logic [DEN_W-1:0]  denominator;
        logic [ITER_W-1:0] iterations;
    } eng_res_t;

    // Engine status toward the top level
    typedef struct packed {
        logic idle;
        logic done;
    } eng_stat_t;

endpackage

// ===== design/cfra_ifs.sv =====
interface cfra_in_if
    import cfra_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [X_W-1:0]   x_fraction;

    modport source (output valid, output x_fraction, input ready);
    modport sink   (input valid, input x_fraction, output ready);
endinterface

interface cfra_out_if
    import cfra_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [NUM_W-1:0]  numerator;
    logic [DEN_W-1:0]  denominator;
    logic [ITER_W-1:0] iterations;

    modport source (output valid, output numerator, output denominator, output iterations,
                    input ready);
    modport sink   (input valid, input numerator, input denominator, input iterations,
                    output ready);
endinterface

// ===== design/continued_fraction_rational_approx.sv =====
// Channel  Dir  Handshake          Payload
// in_ch    in   valid/ready        x_fraction[31:0]
// out_ch   out  valid/ready        numerator[31:0], denominator[32:0], iterations[6:0]
// cfg      in   APB (pready = 1)   tolerance @ 0x0
//
// One transaction at a time; in_ch.ready is high only while the engine is idle.
// Each Euclid step runs the serial divider, after a serial b*tol check when
// tolerance is nonzero; both use the shift/add unit.
// rst_n clears the sequencer, output valid and tolerance (to 0).
// A result waits in the output register while the next transaction is taken.
module continued_fraction_rational_approx
    import cfra_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int MAX_ITER  = MAX_ITER_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    cfra_in_if.sink               in_ch,
    cfra_out_if.source            out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [TOL_W-1:0] tolerance;
    eng_stat_t        stat;
    eng_res_t         res;
    logic             start;
    logic             take;
    logic             out_valid_reg, out_valid_next;
    eng_res_t         out_reg, out_next;

    cfra_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .tolerance (tolerance)
    );

    cfra_engine #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_ITER  (MAX_ITER)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .x_fraction (in_ch.x_fraction),
        .tolerance  (tolerance),
        .take       (take),
        .stat       (stat),
        .res        (res)
    );

    // Input handshake
    assign in_ch.ready = stat.idle;
    assign start       = in_ch.valid && stat.idle;

    // Output register: load when empty or being drained
    assign take = stat.done && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.numerator   = out_reg.numerator;
    assign out_ch.denominator = out_reg.denominator;
    assign out_ch.iterations  = out_reg.iterations;

endmodule

// ===== design/cfra_regs.sv =====
module cfra_regs
    import cfra_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [TOL_W-1:0]      tolerance
);

    logic [TOL_W-1:0]     tol_reg;
    logic [TOL_W-1:0]     tol_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Register write
    always_comb
    begin
        tol_next = tol_reg;
        if (wr_en && reg_idx == REG_TOLERANCE)
        begin
            tol_next = pwdata[TOL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else
        begin
            tol_reg <= tol_next;
        end
    end

    // Readback
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_TOLERANCE)
        begin
            prdata = APB_DATA_W'(tol_reg);
        end
    end

    assign tolerance = tol_reg;

endmodule

// ===== design/cfra_engine.sv =====
module cfra_engine
    import cfra_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int MAX_ITER  = MAX_ITER_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [X_W-1:0]   x_fraction,
    input  logic [TOL_W-1:0] tolerance,
    input  logic             take,
    output eng_stat_t        stat,
    output eng_res_t         res
);

    localparam int F       = FRAC_BITS;
    localparam int W       = FRAC_BITS + 1;
    localparam int CNT_MAX = (W > TOL_W) ? W : TOL_W;
    localparam int CNT_W   = $clog2(CNT_MAX);

    localparam logic [W-1:0]      U_INIT  = {1'b1, {F{1'b0}}};
    localparam logic [W:0]        CAP     = {1'b0, 1'b1, {F{1'b0}}};
    localparam logic [ITER_W-1:0] K_MAX   = ITER_W'(MAX_ITER);
    localparam logic [ITER_W-1:0] K_LIMIT = ITER_W'(MAX_ITER + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DEC   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_UPD   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [ITER_W-1:0] k_reg,     k_next;
    logic [W-1:0]      u_reg,     u_next;
    logic [F-1:0]      v_reg,     v_next;
    logic [W-1:0]      a_reg,     a_next;
    logic [W-1:0]      b_reg,     b_next;
    logic [W-1:0]      ap_reg,    ap_next;
    logic [W-1:0]      bp_reg,    bp_next;
    logic [W:0]        acc_reg,   acc_next;
    logic [TOL_W-1:0]  tsh_reg,   tsh_next;
    logic [W-1:0]      rem_reg,   rem_next;
    logic [W-1:0]      dv_reg,    dv_next;
    logic [W-1:0]      aa_reg,    aa_next;
    logic [W-1:0]      ba_reg,    ba_next;

    logic [W:0]        mul_sum;
    logic [W-1:0]      shifted;
    logic              ge;
    logic              tol_ok;

    // Shared shift/add unit: tolerance product and divider step
    always_comb
    begin
        mul_sum = {acc_reg[W-1:0], 1'b0}
                  + (tsh_reg[TOL_W-1] ? {1'b0, b_reg} : {(W+1){1'b0}});
        shifted = {rem_reg[W-2:0], dv_reg[W-1]};
        ge      = shifted >= {1'b0, v_reg};
        tol_ok  = (tolerance == '0) ? (v_reg == '0) : (acc_reg >= {2'b00, v_reg});
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        ap_next    = ap_reg;
        bp_next    = bp_reg;
        acc_next   = acc_reg;
        tsh_next   = tsh_reg;
        rem_next   = rem_reg;
        dv_next    = dv_reg;
        aa_next    = aa_reg;
        ba_next    = ba_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    u_next     = U_INIT;
                    v_next     = F'(x_fraction);
                    a_next     = '0;
                    b_next     = W'(1);
                    ap_next    = W'(1);
                    bp_next    = '0;
                    k_next     = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // exact tolerance skips the product
                if (tolerance == '0)
                begin
                    state_next = S_DEC;
                end
                else
                begin
                    acc_next   = '0;
                    tsh_next   = tolerance;
                    cnt_next   = CNT_W'(TOL_W - 1);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // MSB-first b*tol, clamped above any remainder
                acc_next = (mul_sum > CAP) ? CAP : mul_sum;
                tsh_next = {tsh_reg[TOL_W-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    state_next = S_DEC;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_DEC:
            begin
                priority if (tol_ok)
                begin
                    state_next = S_DONE;
                end
                else if (k_reg >= K_MAX)
                begin
                    k_next     = K_LIMIT;
                    state_next = S_DONE;
                end
                else if (v_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    dv_next    = u_reg;
                    aa_next    = '0;
                    ba_next    = '0;
                    cnt_next   = CNT_W'(W - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // restoring division, quotient bit folded into q*a and q*b
                rem_next = ge ? (shifted - {1'b0, v_reg}) : shifted;
                dv_next  = {dv_reg[W-2:0], 1'b0};
                aa_next  = {aa_reg[W-2:0], 1'b0} + (ge ? a_reg : {W{1'b0}});
                ba_next  = {ba_reg[W-2:0], 1'b0} + (ge ? b_reg : {W{1'b0}});
                if (cnt_reg == '0)
                begin
                    state_next = S_UPD;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_UPD:
            begin
                // three-term recurrence and Euclid shift
                a_next     = aa_reg + ap_reg;
                b_next     = ba_reg + bp_reg;
                ap_next    = a_reg;
                bp_next    = b_reg;
                u_next     = {1'b0, v_reg};
                v_next     = rem_reg[F-1:0];
                k_next     = k_reg + ITER_W'(1);
                state_next = S_CHECK;
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        u_reg   <= u_next;
        v_reg   <= v_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        ap_reg  <= ap_next;
        bp_reg  <= bp_next;
        acc_reg <= acc_next;
        tsh_reg <= tsh_next;
        rem_reg <= rem_next;
        dv_reg  <= dv_next;
        aa_reg  <= aa_next;
        ba_reg  <= ba_next;
    end

    assign stat.idle       = (state_reg == S_IDLE);
    assign stat.done       = (state_reg == S_DONE);
    assign res.numerator   = NUM_W'(a_reg);
    assign res.denominator = DEN_W'(b_reg);
    assign res.iterations  = k_reg;

`ifndef NO_ASSERTIONS
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> v_reg != '0)
        else $error("divider running with zero divisor");
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < {1'b0, v_reg})
        else $error("partial remainder not below divisor");
    a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPD |=> v_reg < $past(v_reg))
        else $error("Euclid remainder did not decrease");
    a_num_le_den: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DEC |-> (b_reg != '0 && a_reg <= b_reg))
        else $error("convergent out of range");
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> k_reg < K_MAX)
        else $error("step started past iteration limit");
`endif

endmodule

// ===== dv/cfra_checker.sv =====
`timescale 1ns / 1ps

module cfra_checker
    import cfra_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int MAX_ITER  = MAX_ITER_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    cfra_in_if                    in_ch,
    cfra_out_if                   out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    mismatches,
    output int                    pending_results
);

    // One expected convergent, tagged with the input that produced it
    typedef struct {
        logic [X_W-1:0] x;
        eng_res_t       res;
    } approx_t;

    approx_t          approx_q[$];
    logic [TOL_W-1:0] tolerance_q;

    // Continued fraction expansion of x / 2^FRAC_BITS, stopping at the first
    // convergent whose remainder r satisfies r <= tol * q, or at the MAX_ITER limit
    function automatic eng_res_t best_convergent(input logic [X_W-1:0] x,
                                                 input logic [TOL_W-1:0] tol);
        logic [63:0] dividend;
        logic [63:0] divisor;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] p_prev;
        logic [63:0] q_prev;
        logic [63:0] p_next;
        logic [63:0] q_next;
        logic [63:0] need;
        int unsigned k;
        bit          hit;
        bit          done;
        eng_res_t    r;
        dividend = 64'd1 << FRAC_BITS;
        divisor  = {32'd0, x} & (dividend - 64'd1);
        p        = 64'd0;
        q        = 64'd1;
        p_prev   = 64'd1;
        q_prev   = 64'd0;
        k        = 0;
        done     = 1'b0;
        while (!done) begin
            // ceil(r / tol) <= q avoids a wide product
            if (tol == '0) begin
                hit = (divisor == 64'd0);
            end
            else begin
                need = (divisor + {32'd0, tol} - 64'd1) / {32'd0, tol};
                hit  = (q >= need);
            end
            if (hit) begin
                done = 1'b1;
            end
            else if (k >= MAX_ITER) begin
                k    = MAX_ITER + 1;
                done = 1'b1;
            end
            else if (divisor == 64'd0) begin
                done = 1'b1;
            end
            else begin
                quo      = dividend / divisor;
                rem      = dividend % divisor;
                p_next   = quo * p + p_prev;
                q_next   = quo * q + q_prev;
                p_prev   = p;
                q_prev   = q;
                p        = p_next;
                q        = q_next;
                dividend = divisor;
                divisor  = rem;
                k++;
            end
        end
        r.numerator   = p[NUM_W-1:0];
        r.denominator = q[DEN_W-1:0];
        r.iterations  = k[ITER_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] checker: %s", $realtime, msg);
        mismatches++;
    endtask

    initial begin
        mismatches      = 0;
        pending_results = 0;
        tolerance_q     = '0;
    end

    // Monitor: predict on input transactions, compare on output transactions
    always @(posedge clk) begin
        approx_t  want;
        eng_res_t pred;
        if (!rst_n) begin
            tolerance_q = '0;
        end
        else begin
            if (in_ch.valid && in_ch.ready) begin
                pred     = best_convergent(in_ch.x_fraction, tolerance_q);
                want.x   = in_ch.x_fraction;
                want.res = pred;
                approx_q.push_back(want);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (approx_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d/%0d k=%0d",
                                              out_ch.numerator, out_ch.denominator,
                                              out_ch.iterations));
                end
                else begin
                    want = approx_q.pop_front();
                    if (out_ch.numerator !== want.res.numerator)
                        report_mismatch($sformatf("x=%h numerator %0d, want %0d", want.x,
                                                  out_ch.numerator, want.res.numerator));
                    if (out_ch.denominator !== want.res.denominator)
                        report_mismatch($sformatf("x=%h denominator %0d, want %0d", want.x,
                                                  out_ch.denominator, want.res.denominator));
                    if (out_ch.iterations !== want.res.iterations)
                        report_mismatch($sformatf("x=%h iterations %0d, want %0d", want.x,
                                                  out_ch.iterations, want.res.iterations));
                end
            end
            // Register write lands at the access phase
            if (psel && penable && pwrite && pready
                && paddr[APB_ADDR_W-1:2] == REG_TOLERANCE) begin
                tolerance_q = pwdata[TOL_W-1:0];
            end
        end
        pending_results <= approx_q.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import cfra_pkg::*;

    // Bound assumes about 48 Euclid steps, each with the tolerance product
    localparam int LATENCY_MAX    = 48 * (FRAC_BITS_DEF + 36) + 3;
    localparam int WATCHDOG_LIMIT = 6 * LATENCY_MAX;
    localparam int PHASE_ITEMS    = 50;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int pending_results;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles;

    cfra_in_if  in_ch();
    cfra_out_if out_ch();

    continued_fraction_rational_approx dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cfra_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result receiver with random backpressure
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
        else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Mix of uniform values, values near small rationals and values near the ends
    function automatic logic [X_W-1:0] random_fraction();
        int unsigned  den;
        int unsigned  num;
        logic [63:0]  base;
        logic [X_W-1:0] x;
        case ($urandom_range(9, 0))
            6, 7: begin
                den  = $urandom_range(1000, 2);
                num  = $urandom_range(den - 1, 0);
                base = ({32'd0, num} << 32) / den;
                x    = base[X_W-1:0] + X_W'($urandom_range(16, 0)) - X_W'(8);
            end
            8:       x = X_W'($urandom_range(255, 0));
            9:       x = 32'hFFFF_FFFF - X_W'($urandom_range(255, 0));
            default: x = $urandom;
        endcase
        return x;
    endfunction

    // Offer one value; valid stays high if the next one follows at once
    task automatic send_fraction(input logic [X_W-1:0] x);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.x_fraction <= x;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_results();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TOLERANCE, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_directed();
        logic [X_W-1:0] exact_set[$];
        logic [X_W-1:0] loose_set[$];
        logic [X_W-1:0] unit_set[$];
        // zero, one LSB, all ones, exact hits, golden ratio (longest expansion)
        exact_set = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                      32'h4000_0000, 32'hC000_0000, 32'h9E37_79B9, 32'h5555_5555,
                      32'hAAAA_AAAA, 32'h0000_0003, 32'hFFFF_FFFE, 32'h1234_5678};
        loose_set = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h9E37_79B9};
        unit_set  = '{32'h5555_5555, 32'h9E37_79B9, 32'h0000_0001, 32'hFFFF_FFFF};
        write_tolerance('0);
        foreach (exact_set[i]) send_fraction(exact_set[i]);
        wait_results();
        write_tolerance('1);
        foreach (loose_set[i]) send_fraction(loose_set[i]);
        wait_results();
        write_tolerance(TOL_W'(1));
        foreach (unit_set[i]) send_fraction(unit_set[i]);
    endtask

    // Stimulus
    initial begin
        logic [TOL_W-1:0] phase_tol[6];
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.x_fraction <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        stall_cycles     <= 0;
        send_idle_pct     = 35;
        recv_idle_pct     = 87;
        phase_tol = '{TOL_W'(0), TOL_W'(1), TOL_W'($urandom_range(1000, 2)), $urandom,
                      32'hFFFF_FFFF, TOL_W'($urandom_range(1000000, 1000))};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Random phases: receiver-heavy idling, sender-heavy idling, then none
        for (int ph = 0; ph < 6; ph++) begin
            wait_results();
            write_tolerance(phase_tol[ph]);
            send_idle_pct = (ph < 2) ? 35 : (ph < 4) ? 87 : 0;
            recv_idle_pct = (ph < 2) ? 87 : (ph < 4) ? 35 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == PHASE_ITEMS / 2)
                    wait_results();
                send_fraction(random_fraction());
            end
        end

        wait_results();
        repeat (LATENCY_MAX) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
